// ===== rtl/core/mmcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcc_pkg - shared types and constants of the multimode clock counter
// Mode codes, register indexes and the seven-segment decode.
// ----------------------------------------------------------------------------
package mmcc_pkg;

	localparam int unsigned DIGITS     = 4;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned SEG_W      = 7;
	localparam int unsigned HOLD_LIM_W = 15;
	localparam int unsigned HOLD_CNT_W = 16;
	localparam int unsigned SCAN_W     = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [HOLD_LIM_W-1:0] HOLD_LIMIT_RST     = 15'd200;
	localparam logic [SCAN_W-1:0]     SCANS_PER_TICK_RST = 16'd1000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCANS_PER_TICK = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_FREE = 2'd1,
		MODE_H24  = 2'd2,
		MODE_H12  = 2'd3
	} mode_t;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [SEG_W-1:0]   seg_t;

	localparam seg_t SEG_BLANK = 7'h00;
	localparam seg_t SEG_ZERO  = 7'h3F;

	// bit0 = segment a .. bit6 = segment g; anything above nine is blank
	function automatic seg_t seg_decode(input digit_t d);
		seg_t s;
		unique case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/multimode_clock_counter_top.sv =====
// ----------------------------------------------------------------------------
// multimode_clock_counter_top - four-digit BCD clock / counter
// One display scan in, one set of segment codes, lamps and mode out.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  -----------------------------------
//  scan in  input      in_valid / in_stall  button_a_pressed, button_b_pressed
//  result   output     out_valid/out_stall  seg_first..seg_fourth, lamp_morning,
//                                           lamp_evening, mode_now
//  config   input      wr_en                wr_index, wr_data
//
// For each scan, the advance, the segment decode and the button
// evaluation sit between the state registers and the result register, so a
// scan can be accepted on every clock edge and its result shows the next
// cycle. The single result register sets the rate: while it holds a result
// that is stalled, in_stall is raised; once the result transfers, a new scan
// is taken in the same cycle. Reset restores the register defaults (hold
// limit 200, 1000 scans per tick), idle mode, digits 0000, morning flag set
// and both lamps off.
//
module multimode_clock_counter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// scan channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 button_a_pressed,
	input  logic                                 button_b_pressed,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mmcc_pkg::SEG_W-1:0]           seg_first,
	output logic [mmcc_pkg::SEG_W-1:0]           seg_second,
	output logic [mmcc_pkg::SEG_W-1:0]           seg_third,
	output logic [mmcc_pkg::SEG_W-1:0]           seg_fourth,
	output logic                                 lamp_morning,
	output logic                                 lamp_evening,
	output logic [1:0]                           mode_now,
	// configuration
	input  logic                                 wr_en,
	input  logic [mmcc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [mmcc_pkg::CFG_DATA_W-1:0]      wr_data
);
	import mmcc_pkg::*;

	// configuration registers
	logic [HOLD_LIM_W-1:0] hold_limit_q;
	logic [SCAN_W-1:0]     scans_per_tick_q;

	// block state
	digit_t                digit_q [DIGITS];
	mode_t                 mode_q;
	logic                  morning_q;
	logic [1:0]            lamp_q;          // bit0 morning, bit1 evening
	logic [HOLD_CNT_W-1:0] hold_a_q;
	logic [HOLD_CNT_W-1:0] hold_b_q;
	logic [SCAN_W-1:0]     scan_q;

	// result register
	logic                  out_valid_q;
	seg_t                  seg_q [DIGITS];
	logic [1:0]            lamp_out_q;
	mode_t                 mode_out_q;

	// next-state values
	digit_t                adv_digit [DIGITS];   // after the advance, shown
	digit_t                digit_d   [DIGITS];   // after a possible clear
	logic                  morning_d;
	logic [1:0]            lamp_d;
	mode_t                 mode_d;
	logic [HOLD_CNT_W-1:0] hold_a_d;
	logic [HOLD_CNT_W-1:0] hold_b_d;
	logic [SCAN_W-1:0]     scan_inc;
	logic [SCAN_W-1:0]     scan_d;

	logic                  hit_a;
	logic                  hit_b;
	logic                  sel_hit;
	mode_t                 sel_mode;
	digit_t                wrap_hi;
	digit_t                wrap_lo;
	logic                  accept;

	// accept a scan whenever the result register is empty or draining
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// ------------------------------------------------------------------
	// advance on a zero scan count
	// ------------------------------------------------------------------
	assign wrap_hi = (mode_q == MODE_H24) ? 4'd2 : 4'd1;
	assign wrap_lo = (mode_q == MODE_H24) ? 4'd4 : 4'd2;

	always_comb begin
		adv_digit = digit_q;
		morning_d = morning_q;
		lamp_d    = lamp_q;
		if (scan_q == '0) begin
			unique case (mode_q)
				MODE_FREE: begin
					// plain four-digit decimal ripple, 9999 wraps to 0000
					lamp_d = 2'b00;
					if (digit_q[3] != 4'd9) begin
						adv_digit[3] = digit_q[3] + 4'd1;
					end else begin
						adv_digit[3] = '0;
						if (digit_q[2] != 4'd9) begin
							adv_digit[2] = digit_q[2] + 4'd1;
						end else begin
							adv_digit[2] = '0;
							if (digit_q[1] != 4'd9) begin
								adv_digit[1] = digit_q[1] + 4'd1;
							end else begin
								adv_digit[1] = '0;
								if (digit_q[0] != 4'd9) begin
									adv_digit[0] = digit_q[0] + 4'd1;
								end else begin
									adv_digit[0] = '0;
								end
							end
						end
					end
				end
				MODE_H24, MODE_H12: begin
					// minutes 00..59, hours wrap at 24 or 12
					if (digit_q[3] != 4'd9) begin
						adv_digit[3] = digit_q[3] + 4'd1;
					end else begin
						adv_digit[3] = '0;
						if (digit_q[2] < 4'd5) begin
							adv_digit[2] = digit_q[2] + 4'd1;
						end else begin
							adv_digit[2] = '0;
							if (digit_q[0] == wrap_hi &&
							    (digit_q[1] + 4'd1) == wrap_lo) begin
								adv_digit[0] = '0;
								adv_digit[1] = '0;
								if (mode_q == MODE_H12) begin
									morning_d = ~morning_q;
								end
							end else if (digit_q[1] >= 4'd9) begin
								adv_digit[1] = '0;
								adv_digit[0] = digit_q[0] + 4'd1;
							end else begin
								adv_digit[1] = digit_q[1] + 4'd1;
							end
						end
					end
					if (mode_q == MODE_H12) begin
						lamp_d = morning_d ? 2'b01 : 2'b10;
					end else begin
						lamp_d = 2'b00;
					end
				end
				default: begin
					// idle holds the display at zero, lamps untouched
					for (int i = 0; i < DIGITS; i++) begin
						adv_digit[i] = '0;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// button evaluation: button A first, then button B
	// ------------------------------------------------------------------
	assign hit_a = hold_a_q > {1'b0, hold_limit_q};
	assign hit_b = hold_b_q > {1'b0, hold_limit_q};

	always_comb begin
		sel_hit  = 1'b0;
		sel_mode = mode_q;
		priority if (hit_a) begin
			sel_hit  = 1'b1;
			sel_mode = (hold_b_q != '0) ? MODE_H12 : MODE_FREE;
		end else if (hit_b) begin
			// a hit on A clears B, so B only counts when A did not fire
			sel_hit  = 1'b1;
			sel_mode = (hold_a_q != '0) ? MODE_H12 : MODE_H24;
		end else begin
			sel_hit  = 1'b0;
		end
	end

	always_comb begin
		digit_d = adv_digit;
		mode_d  = mode_q;
		if (sel_hit && sel_mode != mode_q) begin
			mode_d = sel_mode;
			for (int i = 0; i < DIGITS; i++) begin
				digit_d[i] = '0;
			end
		end
	end

	// a selection clears both hold counters before this scan's buttons count
	assign hold_a_d = !button_a_pressed ? '0 :
	                  sel_hit ? HOLD_CNT_W'(1) : hold_a_q + HOLD_CNT_W'(1);
	assign hold_b_d = !button_b_pressed ? '0 :
	                  sel_hit ? HOLD_CNT_W'(1) : hold_b_q + HOLD_CNT_W'(1);

	// a zero scans_per_tick compares as always reached, so every scan advances
	assign scan_inc = scan_q + SCAN_W'(1);
	assign scan_d   = (scan_inc >= scans_per_tick_q) ? '0 : scan_inc;

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_limit_q     <= HOLD_LIMIT_RST;
			scans_per_tick_q <= SCANS_PER_TICK_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_HOLD_LIMIT:     hold_limit_q     <= wr_data[HOLD_LIM_W-1:0];
				CFG_SCANS_PER_TICK: scans_per_tick_q <= wr_data[SCAN_W-1:0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				digit_q[i] <= '0;
			end
			mode_q    <= MODE_IDLE;
			morning_q <= 1'b1;
			lamp_q    <= 2'b00;
			hold_a_q  <= '0;
			hold_b_q  <= '0;
			scan_q    <= '0;
		end else if (accept) begin
			digit_q   <= digit_d;
			mode_q    <= mode_d;
			morning_q <= morning_d;
			lamp_q    <= lamp_d;
			hold_a_q  <= hold_a_d;
			hold_b_q  <= hold_b_d;
			scan_q    <= scan_d;
		end
	end

	// result register: fill on an accepted scan, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < DIGITS; i++) begin
				seg_q[i] <= seg_decode(adv_digit[i]);
			end
			lamp_out_q <= lamp_d;
			mode_out_q <= mode_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign seg_first    = seg_q[0];
	assign seg_second   = seg_q[1];
	assign seg_third    = seg_q[2];
	assign seg_fourth   = seg_q[3];
	assign lamp_morning = lamp_out_q[0];
	assign lamp_evening = lamp_out_q[1];
	assign mode_now     = mode_out_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_lamps_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(lamp_morning && lamp_evening))
		else $error("both AM and PM lamps lit");

	a_idle_shows_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mode_now == MODE_IDLE) |->
		(seg_first == SEG_ZERO && seg_second == SEG_ZERO &&
		 seg_third == SEG_ZERO && seg_fourth == SEG_ZERO))
		else $error("idle mode shows a nonzero display");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted scan produced no result");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for the multimode clock counter
// Scans with random button levels go in under random bursts and stalls. Each
// accepted scan is run through an in-bench model of the digits, modes, lamps
// and counters. Every result transfer is compared against the oldest
// predicted display. The register settings are changed between phases.
// ----------------------------------------------------------------------------
module tb;
	import mmcc_pkg::*;

	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned N_FIELDS  = 7;

	// one scan as offered on the input channel
	typedef struct packed {
		logic a;
		logic b;
	} scan_t;

	// one display: four segment codes, two lamps, mode, each in a 7-bit slot
	typedef logic [N_FIELDS-1:0][SEG_W-1:0] display_t;

	// ------------------------------------------------------------------------
	// Display scoreboard: mirrors the block state, predicts one display per
	// accepted scan and checks the result transfers in order.
	// ------------------------------------------------------------------------
	class display_scoreboard;
		display_t               due_displays[$];
		string                  field_name[N_FIELDS];
		logic [HOLD_LIM_W-1:0]  hold_limit;
		logic [SCAN_W-1:0]      scans_per_tick;
		digit_t                 digits[DIGITS];
		mode_t                  mode;
		logic                   morning;
		logic [HOLD_CNT_W-1:0]  held_a;
		logic [HOLD_CNT_W-1:0]  held_b;
		logic [SCAN_W-1:0]      scan_cnt;
		logic [1:0]             lamps;
		int                     errors;

		function new();
			field_name = '{"seg_first", "seg_second", "seg_third", "seg_fourth",
				"lamp_morning", "lamp_evening", "mode_now"};
			hold_limit     = HOLD_LIMIT_RST;
			scans_per_tick = SCANS_PER_TICK_RST;
			clear_digits();
			mode     = MODE_IDLE;
			morning  = 1'b1;
			held_a   = '0;
			held_b   = '0;
			scan_cnt = '0;
			lamps    = 2'b00;
			errors   = 0;
		endfunction

		function void clear_digits();
			foreach (digits[i])
				digits[i] = '0;
		endfunction

		function seg_t glyph(digit_t d);
			case (d)
				4'd0: return 7'h3F;
				4'd1: return 7'h06;
				4'd2: return 7'h5B;
				4'd3: return 7'h4F;
				4'd4: return 7'h66;
				4'd5: return 7'h6D;
				4'd6: return 7'h7D;
				4'd7: return 7'h07;
				4'd8: return 7'h7F;
				4'd9: return 7'h6F;
				default: return 7'h00;
			endcase
		endfunction

		// advance the minutes; report a wrap when the hours reach hi:lo
		function bit count_minutes(digit_t hi, digit_t lo);
			digits[3] = digits[3] + 1'b1;
			if (digits[3] > 4'd9) begin
				digits[3] = '0;
				digits[2] = digits[2] + 1'b1;
				if (digits[2] > 4'd5) begin
					digits[2] = '0;
					digits[1] = digits[1] + 1'b1;
					if (digits[0] == hi && digits[1] == lo) begin
						clear_digits();
						return 1'b1;
					end
					if (digits[1] > 4'd9) begin
						digits[1] = '0;
						digits[0] = digits[0] + 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function void pick_mode(mode_t m);
			held_a = '0;
			held_b = '0;
			if (mode != m) begin
				mode = m;
				clear_digits();
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_HOLD_LIMIT)
				hold_limit = val[HOLD_LIM_W-1:0];
			else if (idx == CFG_SCANS_PER_TICK)
				scans_per_tick = val;
		endfunction

		function int pending();
			return due_displays.size();
		endfunction

		function void note_scan(logic a, logic b);
			display_t shown;
			int       i;
			if (scan_cnt == '0) begin
				case (mode)
					MODE_FREE: begin
						lamps = 2'b00;
						digits[3] = digits[3] + 1'b1;
						for (i = 3; i >= 0; i--) begin
							if (digits[i] > 4'd9) begin
								digits[i] = digits[i] - 4'd10;
								if (i == 0)
									clear_digits();
								else
									digits[i-1] = digits[i-1] + 1'b1;
							end
						end
					end
					MODE_H24: begin
						lamps = 2'b00;
						void'(count_minutes(4'd2, 4'd4));
					end
					MODE_H12: begin
						if (count_minutes(4'd1, 4'd2))
							morning = ~morning;
						lamps = morning ? 2'b01 : 2'b10;
					end
					default: clear_digits();
				endcase
			end
			for (i = 0; i < DIGITS; i++)
				shown[i] = glyph(digits[i]);
			shown[4] = {6'b0, lamps[0]};
			shown[5] = {6'b0, lamps[1]};
			shown[6] = {5'b0, mode};
			due_displays.push_back(shown);

			if (held_a > hold_limit)
				pick_mode(held_b != '0 ? MODE_H12 : MODE_FREE);
			if (held_b > hold_limit)
				pick_mode(held_a != '0 ? MODE_H12 : MODE_H24);
			held_a = a ? held_a + 1'b1 : '0;
			held_b = b ? held_b + 1'b1 : '0;
			scan_cnt = scan_cnt + 1'b1;
			if (scan_cnt >= scans_per_tick)
				scan_cnt = '0;
		endfunction

		function void check_display(display_t got);
			display_t want;
			int       k;
			if (due_displays.size() == 0) begin
				$error("result transfer with no display predicted");
				errors++;
				return;
			end
			want = due_displays.pop_front();
			for (k = 0; k < N_FIELDS; k++) begin
				if (got[k] !== want[k]) begin
					$error("%s: expected %0h, actual %0h", field_name[k], want[k], got[k]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  button_a_pressed;
	logic                  button_b_pressed;
	logic                  out_valid;
	logic                  out_stall;
	seg_t                  seg_first;
	seg_t                  seg_second;
	seg_t                  seg_third;
	seg_t                  seg_fourth;
	logic                  lamp_morning;
	logic                  lamp_evening;
	logic [1:0]            mode_now;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	display_scoreboard sb;
	scan_t             scan_q[$];
	int unsigned       cycle_cnt = 0;

	multimode_clock_counter_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.button_a_pressed (button_a_pressed),
		.button_b_pressed (button_b_pressed),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.seg_first        (seg_first),
		.seg_second       (seg_second),
		.seg_third        (seg_third),
		.seg_fourth       (seg_fourth),
		.lamp_morning     (lamp_morning),
		.lamp_evening     (lamp_evening),
		.mode_now         (mode_now),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	// 10-unit clock, low half first
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: end a run that has not finished by itself, reporting errors
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sender: offer queued scans in bursts of random length with random gaps.
	// Predict on each accepted transfer; hold the payload while stalled.
	// ------------------------------------------------------------------------
	initial begin : sender
		int    burst_left;
		int    gap_left;
		scan_t nxt;
		in_valid         = 1'b0;
		button_a_pressed = 1'b0;
		button_b_pressed = 1'b0;
		burst_left       = 0;
		gap_left         = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall)
				sb.note_scan(button_a_pressed, button_b_pressed);
			if (!in_valid || !in_stall) begin
				// start a new burst, sometimes straight after the last one
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
				if (gap_left == 0 && scan_q.size() > 0) begin
					nxt = scan_q.pop_front();
					in_valid         <= 1'b1;
					button_a_pressed <= nxt.a;
					button_b_pressed <= nxt.b;
					burst_left--;
				end else begin
					if (gap_left > 0)
						gap_left--;
					// scramble the idle payload; it must be ignored
					in_valid         <= 1'b0;
					button_a_pressed <= 1'($urandom_range(0, 1));
					button_b_pressed <= 1'($urandom_range(0, 1));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: stall on a pattern of its own, changing style per stretch.
	// Once, after a few hundred transfers, hold off for a long stretch so the
	// result register fills and the block stalls its input.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int xfer_cnt;
		int hold_left;
		int seg_left;
		int style;
		bit long_done;
		out_stall = 1'b0;
		xfer_cnt  = 0;
		hold_left = 0;
		seg_left  = 0;
		style     = 0;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				xfer_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!long_done && xfer_cnt >= 400) begin
				long_done = 1'b1;
				hold_left = 239;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 64);
					style    = $urandom_range(0, 3);
				end
				seg_left--;
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 70);
					default: out_stall <= (seg_left % 3 == 0);
				endcase
			end
		end
	end

	// check every result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_display({7'(mode_now), 7'(lamp_evening), 7'(lamp_morning),
				seg_fourth, seg_third, seg_second, seg_first});
	end

	function automatic void put(input logic a, input logic b);
		scan_q.push_back(scan_t'({a, b}));
	endfunction

	// Queue n scans: button presses, picked press_pct percent of the time and held
	// around the hold limit (some cut short, both-button presses sometimes led by A), with noise between.
	task automatic queue_scans(input int n, input int hold, input int press_pct);
		int   done_n;
		int   len;
		int   lead;
		int   rel;
		int   k;
		logic pa;
		logic pb;
		done_n = 0;
		while (done_n < n) begin
			if ($urandom_range(0, 99) < press_pct) begin
				{pa, pb} = 2'($urandom_range(1, 3));
				len  = hold + $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0)
					len = len / 2;
				lead = (pa && pb) ? $urandom_range(0, 2) : 0;
				rel  = $urandom_range(1, 5);
				for (k = 0; k < lead; k++)
					put(1'b1, 1'b0);
				for (k = 0; k < len; k++)
					put(pa, pb);
				for (k = 0; k < rel; k++)
					put(1'b0, 1'b0);
				done_n += lead + len + rel;
			end else begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				done_n += len;
			end
		end
	endtask

	// wait until every scan has transferred and every display has come back
	task automatic settle();
		do
			@(negedge clk);
		while (scan_q.size() > 0 || in_valid || sb.pending() > 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en    <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// drain, then load both registers; queue further scans on a falling edge
	task automatic retune(input logic [HOLD_LIM_W-1:0] hold, input logic [SCAN_W-1:0] spt);
		settle();
		write_reg(CFG_HOLD_LIMIT, {1'b0, hold});
		write_reg(CFG_SCANS_PER_TICK, spt);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main
		sb       = new();
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = CFG_HOLD_LIMIT;
		wr_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: an idle advance on the very first scan
		put(1'b0, 1'b0);
		put(1'b1, 1'b1);

		// hold limit zero, advance on every scan: one held scan selects
		retune(15'd0, 16'd1);
		put(1'b1, 1'b0);           // A alone: free-run
		put(1'b0, 1'b0);
		repeat (3) put(1'b0, 1'b0);
		put(1'b0, 1'b1);           // B alone: 24h, digits cleared
		put(1'b0, 1'b0);
		repeat (2) put(1'b0, 1'b0);
		put(1'b1, 1'b1);           // both: 12h, lamp lit
		put(1'b0, 1'b0);
		repeat (2) put(1'b0, 1'b0);
		put(1'b1, 1'b1);           // select 12h again: digits kept
		put(1'b0, 1'b0);
		put(1'b0, 1'b1);           // B leads, then both
		put(1'b1, 1'b1);
		put(1'b0, 1'b0);
		put(1'b1, 1'b0);           // A held on: free-run reselected
		put(1'b1, 1'b0);
		put(1'b0, 1'b0);

		// random phases across the register ranges
		retune(15'd5, 16'd3);
		queue_scans(200, 5, 70);
		retune(15'd0, 16'd1);
		queue_scans(200, 0, 60);

		// land in 12h with cleared digits, then lock the mode with the
		// largest hold limit and run long enough for the 12h wrap
		retune(15'd2, 16'd1);
		repeat (4) put(1'b1, 1'b1);
		put(1'b0, 1'b0);
		retune(15'd32767, 16'd1);
		queue_scans(760, 0, 0);

		// slowest tick, then drop the tick below the scan count reached
		retune(15'd1, 16'd65535);
		queue_scans(150, 1, 70);
		retune(15'd20, 16'd7);
		queue_scans(100, 20, 70);

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
